// File: hw/rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared widths, codes and defaults for the go-back-n sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // payload field widths
  localparam int MODE_W   = 2;
  localparam int SEQ_W    = 8;
  localparam int FIELD_W  = 16;   // index-type fields on the ports
  localparam int WIN_W    = 4;
  localparam int TMO_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // sequence space of the 8-bit sequence number
  localparam int SEQ_SPACE = 256;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_POLL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LIMIT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

  // register reset values
  localparam logic [WIN_W-1:0] WINDOW_RESET  = 4'd5;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd100;

  // parameter defaults
  localparam int MAX_WINDOW_DEF = 8;
  localparam int INDEX_BITS_DEF = 16;

endpackage

// File: hw/rtl/gbn_in_if.sv
// ----------------------------------------------------------------------------
// gbn_in_if
// Event channel into the sender window: poll, ack or start beats.
// ----------------------------------------------------------------------------
interface gbn_in_if;
  import gbn_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [SEQ_W-1:0]   ack_seq;
  logic               ack_good;
  logic [FIELD_W-1:0] packet_total;

  modport source (output valid, output mode, output ack_seq, output ack_good,
                  output packet_total, input ready);
  modport sink   (input valid, input mode, input ack_seq, input ack_good,
                  input packet_total, output ready);
endinterface

// File: hw/rtl/gbn_out_if.sv
// ----------------------------------------------------------------------------
// gbn_out_if
// Result channel of the sender window: one status beat per event.
// ----------------------------------------------------------------------------
interface gbn_out_if;
  import gbn_pkg::*;

  logic               valid;
  logic               ready;
  logic               send_valid;
  logic [FIELD_W-1:0] send_index;
  logic [SEQ_W-1:0]   send_seq;
  logic               send_last;
  logic               went_back;
  logic [FIELD_W-1:0] window_head;
  logic [FIELD_W-1:0] next_to_send;
  logic               done_res;

  modport source (output valid, output send_valid, output send_index, output send_seq,
                  output send_last, output went_back, output window_head,
                  output next_to_send, output done_res, input ready);
  modport sink   (input valid, input send_valid, input send_index, input send_seq,
                  input send_last, input went_back, input window_head,
                  input next_to_send, input done_res, output ready);
endinterface

// File: hw/rtl/go_back_n_sender_window_unit.sv
// The result beat of an event is registered and appears in the cycle after the event is accepted.
// Throughput: one event per cycle while the sink takes results; the window update is a single registered pass.
// Input ready drops only while a result beat is held and the sink is stalling.
// Reset (rst_n low, synchronous) clears indices, tick counter, ring pointers,
// and loads the window limit 5 and timeout_ticks 100. Send-time ring contents are not cleared.
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit
// Go-back-N sender window: issues packets, takes cumulative acks with 8-bit
// sequence wrap, and rewinds to the head on timeout or a bad ack.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit #(
  parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF,
  parameter int INDEX_BITS = gbn_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gbn_in_if.sink                          in_ch,
  gbn_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gbn_pkg::*;

  localparam int IW = INDEX_BITS;
  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = $clog2(2 * MAX_WINDOW);
  localparam int NW = (IW > 9) ? IW : 9;

  // configuration
  logic [WIN_W-1:0] win_limit_r;
  logic [TMO_W-1:0] timeout_ticks_r;

  // window state
  logic [IW-1:0] head_index_r,  head_index_nxt;
  logic [IW-1:0] next_index_r,  next_index_nxt;
  logic [IW-1:0] total_r,       total_nxt;
  logic [31:0]   tick_r,        tick_nxt;
  logic [PW-1:0] rptr_r,        rptr_nxt;
  logic [CW-1:0] ring_count_r,  ring_count_nxt;
  logic [31:0]   send_time_r [MAX_WINDOW];

  // result register
  logic               out_valid_r;
  logic               send_valid_r,  send_valid_nxt;
  logic [FIELD_W-1:0] send_index_r,  send_index_nxt;
  logic [SEQ_W-1:0]   send_seq_r,    send_seq_nxt;
  logic               send_last_r,   send_last_nxt;
  logic               went_back_r,   went_back_nxt;
  logic [FIELD_W-1:0] window_head_r, window_head_nxt;
  logic [FIELD_W-1:0] next_send_r,   next_send_nxt;
  logic               done_r,        done_nxt;

  logic          in_fire;
  logic          ring_we;
  logic [PW-1:0] ring_waddr;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [WIN_W-1:0] w;
    logic [IW-1:0]    room;
    logic [SW-1:0]    slot_sum;
    logic [PW-1:0]    slot;
    logic [31:0]      oldest;
    logic [31:0]      age;
    logic [SEQ_W-1:0] h8;
    logic [8:0]       n_raw;
    logic [NW-1:0]    n_c;
    logic [CW-1:0]    pop;
    logic [SW-1:0]    rsum;
    logic             sent;

    // effective window: zero acts as one, clamp to the ring depth
    if (win_limit_r == '0)
      w = WIN_W'(1);
    else if ({4'b0, win_limit_r} > 8'(MAX_WINDOW))
      w = WIN_W'(MAX_WINDOW);
    else
      w = win_limit_r;

    room     = next_index_r - head_index_r;
    slot_sum = SW'(rptr_r) + SW'(ring_count_r);
    slot     = (slot_sum >= SW'(MAX_WINDOW)) ? PW'(slot_sum - SW'(MAX_WINDOW))
                                             : PW'(slot_sum);
    h8       = head_index_r[SEQ_W-1:0];
    n_raw    = '0;
    n_c      = '0;
    pop      = '0;
    rsum     = '0;
    oldest   = '0;
    age      = '0;
    sent     = 1'b0;

    head_index_nxt  = head_index_r;
    next_index_nxt  = next_index_r;
    total_nxt       = total_r;
    tick_nxt        = tick_r;
    rptr_nxt        = rptr_r;
    ring_count_nxt  = ring_count_r;
    ring_we         = 1'b0;
    ring_waddr      = slot;
    send_valid_nxt  = 1'b0;
    send_index_nxt  = '0;
    send_seq_nxt    = '0;
    send_last_nxt   = 1'b0;
    went_back_nxt   = 1'b0;

    unique case (in_ch.mode)
      MODE_START: begin
        total_nxt      = IW'(in_ch.packet_total);
        head_index_nxt = '0;
        next_index_nxt = '0;
        tick_nxt       = '0;
        rptr_nxt       = '0;
        ring_count_nxt = '0;
      end
      MODE_POLL: begin
        tick_nxt = tick_r + 32'd1;
        if (head_index_r < total_r) begin
          if (room < IW'(w) && next_index_r < total_r &&
              ring_count_r < CW'(MAX_WINDOW)) begin
            sent           = 1'b1;
            send_valid_nxt = 1'b1;
            send_index_nxt = FIELD_W'(next_index_r);
            send_seq_nxt   = next_index_r[SEQ_W-1:0];
            send_last_nxt  = (next_index_r + IW'(1)) == total_r;
            ring_we        = 1'b1;
            ring_count_nxt = ring_count_r + CW'(1);
            next_index_nxt = next_index_r + IW'(1);
          end
          // an empty ring that just took a beat has the fresh stamp at its head
          oldest = (ring_count_r == '0) ? tick_nxt : send_time_r[rptr_r];
          age    = tick_nxt - oldest;
          if ((ring_count_r != '0 || sent) && age > 32'(timeout_ticks_r)) begin
            went_back_nxt  = 1'b1;
            next_index_nxt = head_index_r;
            rptr_nxt       = '0;
            ring_count_nxt = '0;
          end
        end
      end
      MODE_ACK: begin
        if (!in_ch.ack_good) begin
          went_back_nxt  = 1'b1;
          next_index_nxt = head_index_r;
          rptr_nxt       = '0;
          ring_count_nxt = '0;
        end else begin
          if (in_ch.ack_seq >= h8)
            n_raw = {1'b0, in_ch.ack_seq} - {1'b0, h8} + 9'd1;
          else if (({2'b0, h8} + {6'b0, w}) > 10'(SEQ_SPACE) &&
                   ({2'b0, in_ch.ack_seq} + 10'(SEQ_SPACE)) < ({6'b0, w} + {2'b0, h8}))
            n_raw = 9'(10'(SEQ_SPACE) - {2'b0, h8} + {2'b0, in_ch.ack_seq} + 10'd1);
          // never let the head pass the next packet to send
          n_c = (NW'(n_raw) > NW'(room)) ? NW'(room) : NW'(n_raw);
          head_index_nxt = head_index_r + IW'(n_c);
          pop  = (n_c > NW'(ring_count_r)) ? ring_count_r : CW'(n_c);
          ring_count_nxt = ring_count_r - pop;
          rsum = SW'(rptr_r) + SW'(pop);
          rptr_nxt = (rsum >= SW'(MAX_WINDOW)) ? PW'(rsum - SW'(MAX_WINDOW)) : PW'(rsum);
        end
      end
      default: begin
      end
    endcase

    window_head_nxt = FIELD_W'(head_index_nxt);
    next_send_nxt   = FIELD_W'(next_index_nxt);
    done_nxt        = head_index_nxt >= total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_limit_r     <= WINDOW_RESET;
      timeout_ticks_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIN_LIMIT:     win_limit_r     <= cfg_data[WIN_W-1:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data[TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_index_r <= '0;
      next_index_r <= '0;
      total_r      <= '0;
      tick_r       <= '0;
      rptr_r       <= '0;
      ring_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        head_index_r <= head_index_nxt;
        next_index_r <= next_index_nxt;
        total_r      <= total_nxt;
        tick_r       <= tick_nxt;
        rptr_r       <= rptr_nxt;
        ring_count_r <= ring_count_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // send-time ring and result payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire && ring_we)
      send_time_r[ring_waddr] <= tick_nxt;
    if (in_fire) begin
      send_valid_r  <= send_valid_nxt;
      send_index_r  <= send_index_nxt;
      send_seq_r    <= send_seq_nxt;
      send_last_r   <= send_last_nxt;
      went_back_r   <= went_back_nxt;
      window_head_r <= window_head_nxt;
      next_send_r   <= next_send_nxt;
      done_r        <= done_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.send_valid   = send_valid_r;
  assign out_ch.send_index   = send_index_r;
  assign out_ch.send_seq     = send_seq_r;
  assign out_ch.send_last    = send_last_r;
  assign out_ch.went_back    = went_back_r;
  assign out_ch.window_head  = window_head_r;
  assign out_ch.next_to_send = next_send_r;
  assign out_ch.done_res     = done_r;

  // one stamp per packet in flight
  a_ring_matches_flight: assert property (@(posedge clk) disable iff (!rst_n)
    IW'(ring_count_r) == (next_index_r - head_index_r))
    else $error("ring count differs from packets in flight");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.mode == MODE_START |=>
      out_ch.valid && out_ch.window_head == '0 && out_ch.next_to_send == '0)
    else $error("start beat did not clear the window");

  a_back_to_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.went_back |-> out_ch.next_to_send == out_ch.window_head)
    else $error("go-back did not rewind to the head");

  a_seq_of_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.send_valid |->
      out_ch.send_seq == out_ch.send_index[SEQ_W-1:0])
    else $error("sequence number does not match packet index");

endmodule
